// File: hdl/rbrc_pkg.sv
// ----------------------------------------------------------------------------
// rbrc_pkg
// Shared types and constants of the record bit rotation cipher.
// ----------------------------------------------------------------------------
package rbrc_pkg;

  localparam int LEN_W   = 5;
  localparam int SHIFT_W = 9;
  localparam int CFG_AW  = 4;

  localparam logic [1:0] REG_RECORD_LENGTH = 2'd0;
  localparam logic [1:0] REG_SHIFT_BITS    = 2'd1;
  localparam logic [1:0] REG_DECRYPT_MODE  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_shift;
    logic reduce;
    logic prime;
    logic load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic red_done;
    logic out_free;
    logic last;
  } dp_sts_t;

endpackage

// File: hdl/rbrc_ram.sv
// ----------------------------------------------------------------------------
// rbrc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rbrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/rbrc_ctrl.sv
// ----------------------------------------------------------------------------
// rbrc_ctrl
// Sequencer: gathers bytes, reduces the shift, then streams the rotated record.
// ----------------------------------------------------------------------------
module rbrc_ctrl
  import rbrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output state_t  state
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.full) begin
            cmd.load_shift = 1'b1;
            state_nxt      = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (sts.red_done) begin
          cmd.prime = 1'b1;
          state_nxt = ST_LOAD;
        end else begin
          cmd.reduce = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

// File: hdl/rbrc_dp.sv
// ----------------------------------------------------------------------------
// rbrc_dp
// Datapath: record store, shift reduction, byte-wise rotation and output stage.
// ----------------------------------------------------------------------------
module rbrc_dp
  import rbrc_pkg::*;
#(
  parameter int RECORD_MAX = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_cmd_t                   cmd,
  output dp_sts_t                   sts,
  input  logic [LEN_W-1:0]          cfg_len,
  input  logic signed [SHIFT_W-1:0] cfg_shift,
  input  logic                      cfg_dec,
  input  logic [7:0]                in_byte,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [7:0]                out_byte,
  output logic                      out_last
);

  localparam int AW = (RECORD_MAX > 1) ? $clog2(RECORD_MAX) : 1;
  localparam int FW = $clog2(RECORD_MAX + 1);
  localparam int LW = FW + 3;
  localparam int SW = (LW + 2 > 10) ? LW + 2 : 10;

  logic [FW-1:0]        len_eff;
  logic [FW-1:0]        len_m1;
  logic [LW-1:0]        nbits;
  logic signed [SW-1:0] nbits_s;
  logic signed [SW-1:0] shift_ext;
  logic signed [SW-1:0] shift_init;
  logic [LW-1:0]        rot;
  logic [LW-1:0]        start_full;
  logic [AW-1:0]        start_addr;
  logic [AW-1:0]        rd_addr;
  logic                 rd_en;
  logic [7:0]           rd_data;
  logic [15:0]          pair;
  logic [15:0]          pair_sh;

  logic [FW-1:0]        fill_r;
  logic signed [SW-1:0] shift_r;
  logic [AW-1:0]        rd_addr_r;
  logic [AW-1:0]        cnt_r;
  logic [7:0]           prev_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;

  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a,
                                               input logic [FW-1:0] lm1);
    logic [AW-1:0] n;
    if (FW'(a) == lm1) begin
      n = '0;
    end else begin
      n = a + AW'(1);
    end
    return n;
  endfunction

  always_comb begin
    if (cfg_len == '0) begin
      len_eff = FW'(1);
    end else if (32'(cfg_len) > RECORD_MAX) begin
      len_eff = FW'(RECORD_MAX);
    end else begin
      len_eff = FW'(cfg_len);
    end
  end

  assign len_m1     = len_eff - FW'(1);
  assign nbits      = {len_eff, 3'b000};
  assign nbits_s    = $signed(SW'(nbits));
  assign shift_ext  = SW'(cfg_shift);
  assign shift_init = cfg_dec ? -shift_ext : shift_ext;

  assign rot        = shift_r[LW-1:0];
  assign start_full = LW'(len_eff) - LW'(1) - LW'(rot[LW-1:3]);
  assign start_addr = start_full[AW-1:0];

  assign rd_en   = cmd.prime | cmd.load | cmd.emit;
  assign rd_addr = cmd.prime ? start_addr : rd_addr_r;

  rbrc_ram #(
    .WIDTH (8),
    .DEPTH (RECORD_MAX)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pair    = {prev_r, rd_data};
  assign pair_sh = pair >> rot[2:0];

  assign sts.full     = ((FW+1)'(fill_r) + (FW+1)'(1)) >= (FW+1)'(len_eff);
  assign sts.red_done = !shift_r[SW-1] && (shift_r < nbits_s);
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.last     = (FW'(cnt_r) == len_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        fill_r <= sts.full ? '0 : fill_r + FW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_shift) begin
      shift_r <= shift_init;
    end else if (cmd.reduce) begin
      shift_r <= shift_r[SW-1] ? shift_r + nbits_s : shift_r - nbits_s;
    end
    if (rd_en) begin
      rd_addr_r <= next_addr(rd_addr, len_m1);
    end
    if (cmd.load || cmd.emit) begin
      prev_r <= rd_data;
    end
    if (cmd.prime) begin
      cnt_r <= '0;
    end else if (cmd.emit) begin
      cnt_r <= cnt_r + AW'(1);
    end
    if (cmd.emit) begin
      out_byte_r <= pair_sh[7:0];
      out_last_r <= sts.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// File: hdl/record_bit_rotation_cipher.sv
// ----------------------------------------------------------------------------
// record_bit_rotation_cipher
// Gathers bytes into records and emits each record bit-rotated, one byte a
// cycle while the receiver is ready. A byte that does not complete a record
// leaves the input ready for the next byte. After the last byte of a record
// is accepted, the shift is reduced into range, the first byte is read and
// loaded, and the rotated bytes are emitted; input stays stalled until the
// last byte of the record is emitted, also while the receiver holds off.
// Synchronous active-low reset clears the fill count, output valid, the
// sequencer and the registers to length 1, shift 0, encrypt.
// ----------------------------------------------------------------------------
module record_bit_rotation_cipher
  import rbrc_pkg::*;
#(
  parameter int RECORD_MAX = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: [7:0] byte_in
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  // out_tdata: [7:0] byte_out; out_tlast: record_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [LEN_W-1:0]          len_r;
  logic signed [SHIFT_W-1:0] shift_r;
  logic                      dec_r;
  logic                      cfg_wr;
  logic [1:0]                cfg_idx;
  dp_cmd_t                   cmd;
  dp_sts_t                   sts;
  state_t                    state;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_W'(1);
      shift_r <= '0;
      dec_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RECORD_LENGTH: len_r   <= cfg_pwdata[LEN_W-1:0];
        REG_SHIFT_BITS:    shift_r <= $signed(cfg_pwdata[SHIFT_W-1:0]);
        REG_DECRYPT_MODE:  dec_r   <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RECORD_LENGTH: cfg_prdata = {{(32-LEN_W){1'b0}}, len_r};
      REG_SHIFT_BITS:    cfg_prdata = {{(32-SHIFT_W){shift_r[SHIFT_W-1]}}, shift_r};
      REG_DECRYPT_MODE:  cfg_prdata = {31'b0, dec_r};
      default:           cfg_prdata = '0;
    endcase
  end

  rbrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .state     (state)
  );

  rbrc_dp #(
    .RECORD_MAX (RECORD_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_len   (len_r),
    .cfg_shift (shift_r),
    .cfg_dec   (dec_r),
    .in_byte   (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && sts.full) |=> !in_tready)
    else $error("input not stalled after a record completed");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state == ST_EMIT))
    else $error("result appeared outside the emit phase");

  a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_EMIT && sts.out_free && sts.last) |=> (state == ST_IDLE && out_tlast))
    else $error("last byte of a record not flagged");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for record_bit_rotation_cipher. A byte stream is pushed
// through the slave stream port under a series of record length, shift and
// direction settings written over APB. Each accepted byte updates a local copy
// of the record buffer; on a full record the rotated bytes are queued and
// compared in order against the master stream port. Both stream sides idle at
// random, and the receiver holds off for long stretches to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import rbrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RECORD_MAX   = 16;
  localparam int          RANDOM_ITEMS = 300;
  localparam int          SETTLE       = 60;
  localparam int          LONG_HOLD    = 300;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  typedef struct {
    logic [7:0] byte_out;
    logic       record_end;
  } rot_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // cipher settings as last written
  logic [LEN_W-1:0]   cur_length = 5'd1;
  logic [SHIFT_W-1:0] cur_shift = '0;
  logic               cur_decrypt = 1'b0;

  logic [7:0]  held_bytes [RECORD_MAX];
  int unsigned held_count = 0;

  logic [7:0]  byte_q [$];
  rot_byte_t   rotated_q [$];

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_out = 0;
  int unsigned n_records = 0;
  int unsigned n_settings = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  bit          gaps_on = 1'b1;

  record_bit_rotation_cipher #(.RECORD_MAX(RECORD_MAX)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned record_bytes(input logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > RECORD_MAX) return RECORD_MAX;
    return len;
  endfunction

  // store one byte; on a full record queue its rotated bytes
  function automatic void absorb_byte(input logic [7:0] b);
    int unsigned len, nbits, rot, src, i;
    int          amount;
    logic [7:0]  rotated [RECORD_MAX];
    rot_byte_t   item;
    len = record_bytes(cur_length);
    if (held_count < RECORD_MAX) held_bytes[held_count] = b;
    held_count++;
    if (held_count < len) return;
    held_count = 0;
    nbits = len * 8;
    amount = int'($signed(cur_shift)) % int'(nbits);
    if (amount < 0) amount += int'(nbits);
    rot = amount;
    if (cur_decrypt) rot = (nbits - rot) % nbits;
    for (i = 0; i < RECORD_MAX; i++) rotated[i] = '0;
    for (i = 0; i < nbits; i++) begin
      src = (i + nbits - rot) % nbits;
      rotated[i / 8][7 - (i % 8)] = held_bytes[src / 8][7 - (src % 8)];
    end
    for (i = 0; i < len; i++) begin
      item.byte_out   = rotated[i];
      item.record_end = (i + 1 == len);
      rotated_q.push_back(item);
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_byte(in_tdata);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_tdata  <= byte_q.pop_front();
          in_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver back-pressure
  always @(posedge clk) begin
    rot_byte_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_out++;
        if (out_tlast) n_records++;
        if (rotated_q.size() == 0) begin
          $error("byte_out with nothing pending: got %02h last %0b", out_tdata, out_tlast);
          n_errors++;
        end else begin
          want = rotated_q.pop_front();
          if (out_tdata !== want.byte_out) begin
            $error("byte_out expected %02h actual %02h", want.byte_out, out_tdata);
            n_errors++;
          end
          if (out_tlast !== want.record_end) begin
            $error("record_end expected %0b actual %0b", want.record_end, out_tlast);
            n_errors++;
          end
        end
      end
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        stall_left = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_tready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL record_bit_rotation_cipher");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_RECORD_LENGTH: cur_length  = value[LEN_W-1:0];
      REG_SHIFT_BITS:    cur_shift   = value[SHIFT_W-1:0];
      REG_DECRYPT_MODE:  cur_decrypt = value[0];
      default: ;
    endcase
  endtask

  task automatic set_cipher(input logic [LEN_W-1:0] len, input logic [SHIFT_W-1:0] shift,
                            input logic dec);
    cfg_write(REG_RECORD_LENGTH, 32'(len));
    cfg_write(REG_SHIFT_BITS, 32'(shift));
    cfg_write(REG_DECRYPT_MODE, 32'(dec));
    n_settings++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back(b);
    n_queued++;
  endtask

  // wait until every byte is taken and every rotated byte is out, then settle
  task automatic drain();
    while (n_accepted != n_queued) @(posedge clk);
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int unsigned        random_items, phase, len, count, roll, i;
    logic [LEN_W-1:0]   len_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [7:0]         b;

    random_items = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one-byte records, no rotation
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h01);
    drain();

    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    set_cipher(5'd2, 9'd3, 1'b0);
    push_byte(8'hA5);
    push_byte(8'h3C);
    drain();

    // length zero behaves as one, shift of minus one
    set_cipher(5'd0, 9'h1FF, 1'b1);
    push_byte(8'h81);
    drain();

    // oversized length saturates, largest positive shift, decrypt
    set_cipher(5'd31, 9'h0FF, 1'b1);
    for (i = 0; i < RECORD_MAX; i++) push_byte(8'(i * 17 + 3));
    drain();

    // most negative shift; shorten the record while three bytes are held
    set_cipher(5'd4, 9'h100, 1'b0);
    push_byte(8'hF0);
    push_byte(8'h0F);
    push_byte(8'h55);
    drain();
    cfg_write(REG_RECORD_LENGTH, 32'd2);
    push_byte(8'hAA);
    drain();

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) len_reg = 5'd0;
      else if (roll < 16) len_reg = 5'($urandom_range(17, 31));
      else if (roll < 24) len_reg = 5'd16;
      else if (roll < 40) len_reg = 5'($urandom_range(9, 15));
      else len_reg = 5'($urandom_range(1, 8));
      roll = $urandom_range(0, 99);
      if (roll < 3) shift_reg = 9'h100;
      else if (roll < 6) shift_reg = 9'h0FF;
      else if (roll < 9) shift_reg = 9'h000;
      else if (roll < 12) shift_reg = 9'h080;
      else if (roll < 15) shift_reg = 9'h180;
      else shift_reg = 9'($urandom_range(0, 511));
      set_cipher(len_reg, shift_reg, 1'($urandom_range(0, 1)));
      gaps_on = ($urandom_range(0, 3) != 0);

      len = record_bytes(len_reg);
      count = len * (len > 8 ? $urandom_range(1, 2) : $urandom_range(1, 5));
      if (phase % 12 == 3) begin
        hold_asked++;
        count = len * 6;
      end
      if (len > 1 && $urandom_range(0, 4) == 0) count += $urandom_range(1, len - 1);
      for (i = 0; i < count; i++) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) b = 8'h00;
        else if (roll == 1) b = 8'hFF;
        else b = 8'($urandom_range(0, 255));
        push_byte(b);
      end
      random_items += count;
      drain();
      phase++;
    end

    $display("Sent %0d bytes under %0d cipher settings (%0d random phases).",
             n_accepted, n_settings, phase);
    $display("Checked %0d rotated bytes in %0d records.", n_out, n_records);
    if (n_errors == 0 && rotated_q.size() == 0) begin
      $display("PASS record_bit_rotation_cipher");
    end else begin
      $display("FAIL record_bit_rotation_cipher");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/rbrc_pkg.sv
hdl/rbrc_ram.sv
hdl/rbrc_ctrl.sv
hdl/rbrc_dp.sv
hdl/record_bit_rotation_cipher.sv
tb/tb.sv
